// ===== rtl/epf_pkg.sv =====
package epf_pkg;

  localparam int unsigned CfgIdxW = 2;

  localparam logic [CfgIdxW-1:0] CFG_ESCAPE = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_START  = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_END    = 2'd2;

  localparam logic [7:0] ESCAPE_RST = 8'h10;
  localparam logic [7:0] START_RST  = 8'h02;
  localparam logic [7:0] END_RST    = 8'h03;

  localparam logic ACT_HEADER  = 1'b0;
  localparam logic ACT_PAYLOAD = 1'b1;

  typedef struct packed {
    logic        is_hdr;
    logic [7:0]  b0;
    logic [7:0]  b1;
    logic [7:0]  b2;
    logic        close;
    logic [15:0] sum;
  } job_t;

  typedef struct packed {
    logic [7:0] esc_char;
    logic [7:0] start_char;
    logic [7:0] end_char;
  } cfg_t;

endpackage

// ===== rtl/epf_front.sv =====
module epf_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic          in_action,
  input  logic [7:0]    in_message_id,
  input  logic [7:0]    in_flag_bits,
  input  logic [7:0]    in_payload_length,
  input  logic [7:0]    in_payload_byte,
  input  logic          q_full,
  output logic          q_push,
  output epf_pkg::job_t q_job
);
  import epf_pkg::*;

  logic        open_r, open_nxt;
  logic [7:0]  rem_r, rem_nxt;
  logic [15:0] sum_r, sum_nxt;

  logic        acc;
  logic        hdr;
  logic        pay_ok;
  logic [15:0] hdr_sum;
  logic [15:0] pl_sum;
  logic [7:0]  rem_dec;

  assign in_stall = q_full;
  assign acc      = in_valid && !in_stall;
  assign hdr      = (in_action == ACT_HEADER);
  assign pay_ok   = open_r && (rem_r != 8'd0);
  assign hdr_sum  = 16'(in_message_id) + 16'(in_flag_bits) + 16'(in_payload_length);
  assign pl_sum   = sum_r + 16'(in_payload_byte);
  assign rem_dec  = rem_r - 8'd1;

  always_comb begin
    q_job.is_hdr = hdr;
    q_job.b0     = hdr ? in_message_id : in_payload_byte;
    q_job.b1     = in_flag_bits;
    q_job.b2     = in_payload_length;
    q_job.close  = hdr ? (in_payload_length == 8'd0) : (rem_dec == 8'd0);
    q_job.sum    = hdr ? hdr_sum : pl_sum;
  end

  assign q_push = acc && (hdr || pay_ok);

  always_comb begin
    open_nxt = open_r;
    rem_nxt  = rem_r;
    sum_nxt  = sum_r;
    if (acc && hdr) begin
      if (in_payload_length == 8'd0) begin
        open_nxt = 1'b0;
        rem_nxt  = 8'd0;
        sum_nxt  = 16'd0;
      end else begin
        open_nxt = 1'b1;
        rem_nxt  = in_payload_length;
        sum_nxt  = hdr_sum;
      end
    end else if (acc && pay_ok) begin
      if (rem_dec == 8'd0) begin
        open_nxt = 1'b0;
        rem_nxt  = 8'd0;
        sum_nxt  = 16'd0;
      end else begin
        rem_nxt  = rem_dec;
        sum_nxt  = pl_sum;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r <= 1'b0;
      rem_r  <= 8'd0;
      sum_r  <= 16'd0;
    end else begin
      open_r <= open_nxt;
      rem_r  <= rem_nxt;
      sum_r  <= sum_nxt;
    end
  end

endmodule

// ===== rtl/epf_queue.sv =====
module epf_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  epf_pkg::job_t push_job,
  output logic          full,
  input  logic          pop,
  output logic          pop_valid,
  output epf_pkg::job_t pop_job
);
  import epf_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  job_t          mem [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_push;
  logic          do_pop;

  assign full      = (cnt_r == CW'(DEPTH));
  assign pop_valid = (cnt_r != '0);
  assign pop_job   = mem[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && pop_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

// ===== rtl/epf_back.sv =====
module epf_back (
  input  logic          clk,
  input  logic          rst_n,
  input  epf_pkg::cfg_t cfg,
  input  logic          q_valid,
  input  epf_pkg::job_t q_job,
  output logic          q_pop,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [7:0]    out_tx_byte,
  output logic          out_run_last,
  output logic          out_frame_end
);
  import epf_pkg::*;

  localparam logic [3:0] ST_ESC_S = 4'd0;
  localparam logic [3:0] ST_START = 4'd1;
  localparam logic [3:0] ST_D0    = 4'd2;
  localparam logic [3:0] ST_D1    = 4'd3;
  localparam logic [3:0] ST_D2    = 4'd4;
  localparam logic [3:0] ST_SLO   = 4'd5;
  localparam logic [3:0] ST_SHI   = 4'd6;
  localparam logic [3:0] ST_ESC_E = 4'd7;
  localparam logic [3:0] ST_END   = 4'd8;

  logic       act_r, act_nxt;
  job_t       job_r, job_nxt;
  logic [3:0] step_r, step_nxt;
  logic       dup_r, dup_nxt;
  logic       ov_r, ov_nxt;
  logic [7:0] tx_r, tx_nxt;
  logic       last_r, last_nxt;
  logic       end_r, end_nxt;

  logic       adv;
  logic       is_data;
  logic [7:0] dbyte;
  logic       esc_first;
  logic [7:0] ebyte;
  logic [3:0] next_step;
  logic       job_done;
  logic       fin;
  logic       emit;
  logic       load;

  assign adv = !ov_r || !out_stall;

  always_comb begin
    is_data   = 1'b0;
    dbyte     = job_r.b0;
    ebyte     = cfg.esc_char;
    next_step = step_r;
    job_done  = 1'b0;
    unique case (step_r)
      ST_ESC_S: begin
        ebyte     = cfg.esc_char;
        next_step = ST_START;
      end
      ST_START: begin
        ebyte     = cfg.start_char;
        next_step = ST_D0;
      end
      ST_D0: begin
        is_data   = 1'b1;
        dbyte     = job_r.b0;
        next_step = job_r.is_hdr ? ST_D1 : ST_SLO;
        job_done  = !job_r.is_hdr && !job_r.close;
      end
      ST_D1: begin
        is_data   = 1'b1;
        dbyte     = job_r.b1;
        next_step = ST_D2;
      end
      ST_D2: begin
        is_data   = 1'b1;
        dbyte     = job_r.b2;
        next_step = ST_SLO;
        job_done  = !job_r.close;
      end
      ST_SLO: begin
        is_data   = 1'b1;
        dbyte     = job_r.sum[7:0];
        next_step = ST_SHI;
      end
      ST_SHI: begin
        is_data   = 1'b1;
        dbyte     = job_r.sum[15:8];
        next_step = ST_ESC_E;
      end
      ST_ESC_E: begin
        ebyte     = cfg.esc_char;
        next_step = ST_END;
      end
      ST_END: begin
        ebyte     = cfg.end_char;
        job_done  = 1'b1;
      end
      default: begin
        job_done  = 1'b1;
      end
    endcase
    esc_first = is_data && (dbyte == cfg.esc_char) && !dup_r;
    if (is_data) begin
      ebyte = esc_first ? cfg.esc_char : dbyte;
    end
  end

  assign emit  = act_r && adv;
  assign fin   = job_done && !esc_first;
  assign load  = !act_r || (emit && fin);
  assign q_pop = load && q_valid;

  always_comb begin
    act_nxt  = act_r;
    job_nxt  = job_r;
    step_nxt = step_r;
    dup_nxt  = dup_r;
    ov_nxt   = ov_r;
    tx_nxt   = tx_r;
    last_nxt = last_r;
    end_nxt  = end_r;
    if (emit) begin
      ov_nxt   = 1'b1;
      tx_nxt   = ebyte;
      last_nxt = fin;
      end_nxt  = (step_r == ST_END);
      if (esc_first) begin
        dup_nxt = 1'b1;
      end else begin
        dup_nxt  = 1'b0;
        step_nxt = next_step;
      end
    end else if (adv) begin
      ov_nxt = 1'b0;
    end
    if (q_pop) begin
      act_nxt  = 1'b1;
      job_nxt  = q_job;
      step_nxt = q_job.is_hdr ? ST_ESC_S : ST_D0;
      dup_nxt  = 1'b0;
    end else if (load) begin
      act_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    job_r  <= job_nxt;
    tx_r   <= tx_nxt;
    last_r <= last_nxt;
    end_r  <= end_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r  <= 1'b0;
      step_r <= ST_ESC_S;
      dup_r  <= 1'b0;
      ov_r   <= 1'b0;
    end else begin
      act_r  <= act_nxt;
      step_r <= step_nxt;
      dup_r  <= dup_nxt;
      ov_r   <= ov_nxt;
    end
  end

  assign out_valid     = ov_r;
  assign out_tx_byte   = tx_r;
  assign out_run_last  = last_r;
  assign out_frame_end = end_r;

endmodule

// ===== rtl/escaped_packet_framer_core.sv =====
// Escaped packet framer.
// Input channel (in_valid/in_stall): a header item (in_action = 0) opens a frame and
// yields escape, start, id, flags, length; a payload item (in_action = 1) yields one
// payload byte. The last payload item, or a header with length zero, also yields the
// 16-bit sum (low byte first) and escape, end. Data bytes equal to escape go out twice.
// A payload item with no frame open is taken and dropped; a header mid-frame abandons
// the open frame.
// Output channel (out_valid/out_stall): one byte per item, out_run_last on the final
// byte of an input item, out_frame_end on the end marker.
// Config port (cfg_we/cfg_index/cfg_data): escape, start, end characters; write only
// while idle. Indexes beyond the list are ignored.
// Throughput: one output byte per cycle while out_stall is low and jobs are pending,
// set by the single output register; a header yields 5 to 14 bytes, a payload item
// 1 to 2 bytes plus 4 to 6 when it closes. The job queue of QUEUE_DEPTH entries lets
// input run ahead; in_stall rises when full. Reset clears frame state, the queue and
// the output valid flag and loads the default characters. While out_stall is high
// the shown byte holds and the queue fills up.
module escaped_packet_framer_core #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [epf_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [7:0]                 cfg_data,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       in_action,
  input  logic [7:0]                 in_message_id,
  input  logic [7:0]                 in_flag_bits,
  input  logic [7:0]                 in_payload_length,
  input  logic [7:0]                 in_payload_byte,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [7:0]                 out_tx_byte,
  output logic                       out_run_last,
  output logic                       out_frame_end
);
  import epf_pkg::*;

  cfg_t cfg_r, cfg_nxt;
  logic q_full;
  logic q_push;
  job_t push_job;
  logic q_pop;
  logic q_valid;
  job_t pop_job;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_ESCAPE: cfg_nxt.esc_char   = cfg_data;
        CFG_START:  cfg_nxt.start_char = cfg_data;
        CFG_END:    cfg_nxt.end_char   = cfg_data;
        default:    cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.esc_char   <= ESCAPE_RST;
      cfg_r.start_char <= START_RST;
      cfg_r.end_char   <= END_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  epf_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_action         (in_action),
    .in_message_id     (in_message_id),
    .in_flag_bits      (in_flag_bits),
    .in_payload_length (in_payload_length),
    .in_payload_byte   (in_payload_byte),
    .q_full            (q_full),
    .q_push            (q_push),
    .q_job             (push_job)
  );

  epf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_job  (push_job),
    .full      (q_full),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_job   (pop_job)
  );

  epf_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg_r),
    .q_valid       (q_valid),
    .q_job         (pop_job),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_tx_byte   (out_tx_byte),
    .out_run_last  (out_run_last),
    .out_frame_end (out_frame_end)
  );

endmodule

// ===== rtl/epf_checker.sv =====
module epf_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_tx_byte,
  input logic       out_run_last,
  input logic       out_frame_end
);

  a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_end |-> out_run_last)
    else $error("frame end byte not marked as last of its item");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_tx_byte)
      && $stable(out_run_last) && $stable(out_frame_end))
    else $error("stalled output item changed");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid)
    else $error("input item withdrawn while stalled");

endmodule

bind escaped_packet_framer_core epf_checker u_epf_checker (.*);

// ===== sim/escaped_packet_framer_core_tb.sv =====
module escaped_packet_framer_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import epf_pkg::*;

  localparam logic [CfgIdxW-1:0] CFG_UNUSED = 2'd3;
  localparam int IDLE_LIMIT = 2000;
  localparam int SETTLE = 40;
  localparam int LONG_HOLD = 300;
  localparam int LONG_HOLD_AT = 400;

  typedef struct packed {
    logic       action;
    logic [7:0] msg_id;
    logic [7:0] flags;
    logic [7:0] plen;
    logic [7:0] pbyte;
  } frame_item_t;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       run_last;
    logic       frame_end;
  } tx_beat_t;

  // fixed_bytes holds the typed stream right-aligned, first byte leftmost
  typedef struct packed {
    logic               is_cfg;
    logic [CfgIdxW-1:0] cidx;
    logic [7:0]         cdata;
    frame_item_t        it;
    logic               has_fixed;
    logic [4:0]         fixed_n;
    logic [111:0]       fixed_bytes;
  } stim_row_t;

  logic               clk;
  logic               rst_n;
  logic               cfg_we;
  logic [CfgIdxW-1:0] cfg_index;
  logic [7:0]         cfg_data;
  logic               in_valid;
  logic               in_stall;
  logic               in_action;
  logic [7:0]         in_message_id;
  logic [7:0]         in_flag_bits;
  logic [7:0]         in_payload_length;
  logic [7:0]         in_payload_byte;
  logic               out_valid;
  logic               out_stall;
  logic [7:0]         out_tx_byte;
  logic               out_run_last;
  logic               out_frame_end;

  logic [7:0]  esc_c;
  logic [7:0]  sof_c;
  logic [7:0]  eof_c;
  logic        fr_open;
  logic [7:0]  fr_left;
  logic [15:0] fr_sum;

  tx_beat_t step_beats[$];
  tx_beat_t tx_expect[$];

  int n_err = 0;
  int n_rx = 0;
  int n_items = 0;
  int n_offered = 0;
  int idle_cycles = 0;

  escaped_packet_framer_core u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_action         (in_action),
    .in_message_id     (in_message_id),
    .in_flag_bits      (in_flag_bits),
    .in_payload_length (in_payload_length),
    .in_payload_byte   (in_payload_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_tx_byte       (out_tx_byte),
    .out_run_last      (out_run_last),
    .out_frame_end     (out_frame_end)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic void put_raw(logic [7:0] b, logic fe);
    tx_beat_t t;
    t.tx_byte   = b;
    t.run_last  = 1'b0;
    t.frame_end = fe;
    step_beats.push_back(t);
  endfunction

  function automatic void put_stuffed(logic [7:0] b);
    if (b == esc_c) put_raw(esc_c, 1'b0);
    put_raw(b, 1'b0);
  endfunction

  function automatic void seal_frame();
    put_stuffed(fr_sum[7:0]);
    put_stuffed(fr_sum[15:8]);
    put_raw(esc_c, 1'b0);
    put_raw(eof_c, 1'b1);
    fr_open = 1'b0;
    fr_left = 8'd0;
    fr_sum  = 16'd0;
  endfunction

  function automatic void tx_stream_predict(frame_item_t it);
    step_beats.delete();
    if (it.action == ACT_HEADER) begin
      fr_sum  = {8'h00, it.msg_id} + {8'h00, it.flags} + {8'h00, it.plen};
      fr_open = 1'b1;
      fr_left = it.plen;
      put_raw(esc_c, 1'b0);
      put_raw(sof_c, 1'b0);
      put_stuffed(it.msg_id);
      put_stuffed(it.flags);
      put_stuffed(it.plen);
      if (it.plen == 8'd0) seal_frame();
    end else if (fr_open && fr_left != 8'd0) begin
      fr_sum  = fr_sum + {8'h00, it.pbyte};
      fr_left = fr_left - 8'd1;
      put_stuffed(it.pbyte);
      if (fr_left == 8'd0) seal_frame();
    end
  endfunction

  function automatic stim_row_t mk_item(input logic act, input logic [7:0] id, fl, len, pb);
    stim_row_t r;
    r = '0;
    r.it.action = act;
    r.it.msg_id = id;
    r.it.flags  = fl;
    r.it.plen   = len;
    r.it.pbyte  = pb;
    return r;
  endfunction

  function automatic stim_row_t mk_fixed(input logic act, input logic [7:0] id, fl, len, pb,
                                         input int n, input logic [111:0] bytes);
    stim_row_t r;
    r = mk_item(act, id, fl, len, pb);
    r.has_fixed   = 1'b1;
    r.fixed_n     = 5'(n);
    r.fixed_bytes = bytes;
    return r;
  endfunction

  function automatic stim_row_t mk_cfg(input logic [CfgIdxW-1:0] idx, input logic [7:0] d);
    stim_row_t r;
    r = '0;
    r.is_cfg = 1'b1;
    r.cidx   = idx;
    r.cdata  = d;
    return r;
  endfunction

  function automatic logic [7:0] pick_byte();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    if ($urandom_range(0, 3) == 0) b = esc_c;
    return b;
  endfunction

  function automatic logic [7:0] rnd_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  // enter and leave at a falling edge
  task automatic send_item(stim_row_t r);
    int gap;
    int nf;
    int k;
    tx_beat_t b;
    if ((n_offered / 40) % 3 == 1) gap = 0;
    else gap = $urandom_range(0, 11);
    n_offered++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid          <= 1'b1;
    in_action         <= r.it.action;
    in_message_id     <= r.it.msg_id;
    in_flag_bits      <= r.it.flags;
    in_payload_length <= r.it.plen;
    in_payload_byte   <= r.it.pbyte;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    tx_stream_predict(r.it);
    if (r.has_fixed) begin
      nf = r.fixed_n;
      step_beats.delete();
      for (k = 0; k < nf; k++) begin
        b.tx_byte   = r.fixed_bytes[8*(nf-1-k) +: 8];
        b.run_last  = 1'b0;
        b.frame_end = (k == nf - 1);
        step_beats.push_back(b);
      end
    end
    foreach (step_beats[j]) begin
      b = step_beats[j];
      b.run_last = (j == step_beats.size() - 1);
      tx_expect.push_back(b);
    end
    if (step_beats.size() > 0) n_items++;
    @(negedge clk);
  endtask

  task automatic cfg_write(logic [CfgIdxW-1:0] idx, logic [7:0] d);
    in_valid <= 1'b0;
    while (tx_expect.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_ESCAPE: esc_c = d;
      CFG_START:  sof_c = d;
      CFG_END:    eof_c = d;
      default: ;
    endcase
  endtask

  task automatic set_chars(logic [7:0] e, logic [7:0] s, logic [7:0] f);
    cfg_write(CFG_ESCAPE, e);
    cfg_write(CFG_START, s);
    cfg_write(CFG_END, f);
  endtask

  task automatic send_frame(int len, int sent);
    int k;
    send_item(mk_item(ACT_HEADER, pick_byte(), pick_byte(), 8'(len), rnd_byte()));
    for (k = 0; k < sent; k++)
      send_item(mk_item(ACT_PAYLOAD, rnd_byte(), rnd_byte(), rnd_byte(), pick_byte()));
  endtask

  task automatic random_phase(int p);
    int goal;
    int len;
    int sent;
    int r;
    logic [7:0] e;
    goal = n_items + ((p == 3) ? 270 : 26);
    case (p)
      0: set_chars(ESCAPE_RST, START_RST, END_RST);
      1: set_chars(8'h00, 8'hFF, 8'h00);
      2: set_chars(8'hFF, 8'h00, 8'hFF);
      4: begin
        e = rnd_byte();
        set_chars(e, e, rnd_byte());
        cfg_write(CFG_UNUSED, rnd_byte());
      end
      default: set_chars(rnd_byte(), rnd_byte(), rnd_byte());
    endcase
    if (p == 3) send_frame(255, 255);
    while (n_items < goal) begin
      r = $urandom_range(0, 99);
      if (r < 8) begin
        send_item(mk_item(ACT_PAYLOAD, rnd_byte(), rnd_byte(), rnd_byte(), rnd_byte()));
      end else begin
        if (r < 70) len = $urandom_range(0, 4);
        else if (r < 94) len = $urandom_range(5, 16);
        else len = $urandom_range(17, 40);
        sent = len;
        if (len > 0 && $urandom_range(0, 7) == 0) sent = $urandom_range(0, len - 1);
        send_frame(len, sent);
      end
    end
    while (fr_open)
      send_item(mk_item(ACT_PAYLOAD, rnd_byte(), rnd_byte(), rnd_byte(), pick_byte()));
  endtask

  initial begin : stim
    stim_row_t dir_rows[$];
    int p;
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_index         = CFG_ESCAPE;
    cfg_data          = 8'h00;
    in_valid          = 1'b0;
    in_action         = ACT_HEADER;
    in_message_id     = 8'h00;
    in_flag_bits      = 8'h00;
    in_payload_length = 8'h00;
    in_payload_byte   = 8'h00;
    esc_c             = ESCAPE_RST;
    sof_c             = START_RST;
    eof_c             = END_RST;
    fr_open           = 1'b0;
    fr_left           = 8'd0;
    fr_sum            = 16'd0;

    dir_rows.push_back(mk_fixed(ACT_PAYLOAD, 8'h00, 8'h00, 8'h00, 8'hAA, 0, '0));
    dir_rows.push_back(mk_fixed(ACT_HEADER, 8'h00, 8'h00, 8'h00, 8'h00, 9,
                                112'h10_02_00_00_00_00_00_10_03));
    dir_rows.push_back(mk_fixed(ACT_HEADER, 8'hFF, 8'hFF, 8'h00, 8'hFF, 9,
                                112'h10_02_FF_FF_00_FE_01_10_03));
    dir_rows.push_back(mk_fixed(ACT_HEADER, 8'h10, 8'h10, 8'h00, 8'h10, 11,
                                112'h10_02_10_10_10_10_00_20_00_10_03));
    dir_rows.push_back(mk_item(ACT_HEADER, 8'h01, 8'h02, 8'h03, 8'h5A));
    dir_rows.push_back(mk_item(ACT_PAYLOAD, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    dir_rows.push_back(mk_item(ACT_PAYLOAD, 8'h00, 8'h00, 8'h00, 8'h10));
    dir_rows.push_back(mk_item(ACT_PAYLOAD, 8'hA5, 8'h5A, 8'hC3, 8'h00));
    dir_rows.push_back(mk_item(ACT_HEADER, 8'h05, 8'h06, 8'h02, 8'h00));
    dir_rows.push_back(mk_item(ACT_PAYLOAD, 8'h00, 8'h00, 8'h00, 8'h01));
    dir_rows.push_back(mk_item(ACT_HEADER, 8'h07, 8'h08, 8'h01, 8'h00));
    dir_rows.push_back(mk_item(ACT_PAYLOAD, 8'h00, 8'h00, 8'h00, 8'h09));
    dir_rows.push_back(mk_fixed(ACT_PAYLOAD, 8'h00, 8'h00, 8'h00, 8'h33, 0, '0));
    dir_rows.push_back(mk_item(ACT_HEADER, 8'h80, 8'h7F, 8'hFF, 8'h00));
    dir_rows.push_back(mk_item(ACT_PAYLOAD, 8'h00, 8'h00, 8'h00, 8'h10));
    dir_rows.push_back(mk_item(ACT_HEADER, 8'h10, 8'h00, 8'h01, 8'h00));
    dir_rows.push_back(mk_item(ACT_PAYLOAD, 8'h00, 8'h00, 8'h00, 8'hF0));
    dir_rows.push_back(mk_cfg(CFG_ESCAPE, 8'h00));
    dir_rows.push_back(mk_fixed(ACT_HEADER, 8'h00, 8'h00, 8'h00, 8'h00, 14,
                                112'h00_02_00_00_00_00_00_00_00_00_00_00_00_03));
    dir_rows.push_back(mk_cfg(CFG_ESCAPE, 8'hFF));
    dir_rows.push_back(mk_cfg(CFG_START, 8'hFF));
    dir_rows.push_back(mk_cfg(CFG_END, 8'hFF));
    dir_rows.push_back(mk_fixed(ACT_HEADER, 8'hFF, 8'hFF, 8'h00, 8'h00, 11,
                                112'hFF_FF_FF_FF_FF_FF_00_FE_01_FF_FF));
    dir_rows.push_back(mk_cfg(CFG_UNUSED, 8'h55));
    dir_rows.push_back(mk_item(ACT_HEADER, 8'h55, 8'h01, 8'h01, 8'h00));
    dir_rows.push_back(mk_item(ACT_PAYLOAD, 8'h00, 8'h00, 8'h00, 8'h55));

    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) cfg_write(dir_rows[i].cidx, dir_rows[i].cdata);
      else send_item(dir_rows[i]);
    end
    for (p = 0; p < 6; p++) random_phase(p);

    in_valid <= 1'b0;
    while (tx_expect.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
    if (n_err == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

  // output side: random hold-offs, burst stretches, one long hold
  initial begin : sink
    int g;
    bit long_done;
    long_done = 1'b0;
    out_stall = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if (!long_done && n_rx >= LONG_HOLD_AT) begin
        long_done = 1'b1;
        g = LONG_HOLD;
      end else if ((n_rx / 64) % 3 == 2) begin
        g = 0;
      end else begin
        g = $urandom_range(0, 11);
      end
      if (g > 0) begin
        out_stall <= 1'b1;
        repeat (g) @(negedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin : check_tx
    tx_beat_t want;
    if (rst_n && out_valid && !out_stall) begin
      n_rx++;
      if (tx_expect.size() == 0) begin
        n_err++;
        if (n_err <= 10)
          $display("unexpected byte %h last %b end %b", out_tx_byte, out_run_last,
                   out_frame_end);
      end else begin
        want = tx_expect.pop_front();
        if (out_tx_byte !== want.tx_byte || out_run_last !== want.run_last ||
            out_frame_end !== want.frame_end) begin
          n_err++;
          if (n_err <= 10)
            $display("mismatch: exp byte %h last %b end %b, got byte %h last %b end %b",
                     want.tx_byte, want.run_last, want.frame_end,
                     out_tx_byte, out_run_last, out_frame_end);
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

endmodule

// ===== files.f =====
rtl/epf_pkg.sv
rtl/epf_front.sv
rtl/epf_queue.sv
rtl/epf_back.sv
rtl/escaped_packet_framer_core.sv
rtl/epf_checker.sv
sim/escaped_packet_framer_core_tb.sv
